// ----- rtl/nps_pkg.sv -----
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the nearest palette colour search block.
// ----------------------------------------------------------------------------
package nps_pkg;

    // Field widths of the words on the ports.
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned SIZE_W  = 9;
    localparam int unsigned IDX_W   = 8;

    // Squared channel difference and the sum of three of them.
    localparam int unsigned SQ_W   = 2 * CHAN_W;
    localparam int unsigned DIST_W = SQ_W + 2;

    // Starting distance: larger than any real distance, so the first entry wins.
    localparam logic [DIST_W-1:0] DIST_START = '1;

    // Action codes.
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;       // store the incoming entry colour
        logic clear_best;  // capture the raw colour and reset the running best
        logic rd_en;       // read one palette entry into the distance pipeline
    } nps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;   // an entry is still travelling through the pipeline
    } nps_status_t;

endpackage

// ----- rtl/nps_datapath.sv -----
// ----------------------------------------------------------------------------
// nps_datapath
// Palette memory, distance pipeline and running minimum tracker.
// ----------------------------------------------------------------------------
module nps_datapath #(
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nps_pkg::nps_cmd_t                   cmd,
    input  logic [$clog2(PALETTE_DEPTH)-1:0]    rd_addr,
    input  logic [nps_pkg::IDX_W-1:0]           wr_index,
    input  logic [nps_pkg::COLOR_W-1:0]         wr_color,
    input  logic [nps_pkg::COLOR_W-1:0]         raw_color,
    output nps_pkg::nps_status_t                status,
    output logic [nps_pkg::IDX_W-1:0]           best_index
);

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);

    logic [nps_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];

    logic [nps_pkg::COLOR_W-1:0] raw_reg;
    logic [nps_pkg::COLOR_W-1:0] entry_reg;
    logic [AW-1:0]               s1_idx_reg;
    logic                        s1_valid_reg;

    logic [nps_pkg::SQ_W-1:0]    sq_reg [3];
    logic [AW-1:0]               s2_idx_reg;
    logic                        s2_valid_reg;

    logic [nps_pkg::DIST_W-1:0]  best_dist_reg;
    logic [nps_pkg::DIST_W-1:0]  best_dist_next;
    logic [AW-1:0]               best_idx_reg;
    logic [AW-1:0]               best_idx_next;

    logic [nps_pkg::SQ_W-1:0]    sq_next [3];
    logic [nps_pkg::DIST_W-1:0]  entry_dist;

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[AW'(wr_index)] <= wr_color;
        end
        if (cmd.rd_en)
        begin
            entry_reg <= mem[rd_addr];
        end
    end

    // Squared differences of the three channels.
    always_comb
    begin
        logic [nps_pkg::CHAN_W-1:0] ca;
        logic [nps_pkg::CHAN_W-1:0] cb;
        logic [nps_pkg::CHAN_W-1:0] ad;
        for (int c = 0; c < 3; c++)
        begin
            ca = raw_reg[c*nps_pkg::CHAN_W +: nps_pkg::CHAN_W];
            cb = entry_reg[c*nps_pkg::CHAN_W +: nps_pkg::CHAN_W];
            ad = (ca >= cb) ? (ca - cb) : (cb - ca);
            sq_next[c] = nps_pkg::SQ_W'(ad) * nps_pkg::SQ_W'(ad);
        end
    end

    assign entry_dist = nps_pkg::DIST_W'(sq_reg[0]) + nps_pkg::DIST_W'(sq_reg[1])
                      + nps_pkg::DIST_W'(sq_reg[2]);

    // Strictly smaller keeps the lowest index among equal distances.
    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        if (cmd.clear_best)
        begin
            best_dist_next = nps_pkg::DIST_START;
            best_idx_next  = '0;
        end
        else if (s2_valid_reg && (entry_dist < best_dist_reg))
        begin
            best_dist_next = entry_dist;
            best_idx_next  = s2_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.rd_en;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_best)
        begin
            raw_reg <= raw_color;
        end
        s1_idx_reg    <= rd_addr;
        s2_idx_reg    <= s1_idx_reg;
        sq_reg        <= sq_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
    end

    assign status.pipe_busy = s1_valid_reg | s2_valid_reg;
    assign best_index       = nps_pkg::IDX_W'(best_idx_reg);

endmodule

// ----- rtl/nps_ctrl.sv -----
// ----------------------------------------------------------------------------
// nps_ctrl
// Sequencer of the search: accepts words, holds the size register and steps
// the read address through the palette.
// ----------------------------------------------------------------------------
module nps_ctrl #(
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                action,
    input  logic [nps_pkg::IDX_W-1:0]           entry_index,
    input  logic                                cfg_wr_en,
    input  logic [nps_pkg::SIZE_W-1:0]          cfg_wr_data,
    input  nps_pkg::nps_status_t                status,
    output nps_pkg::nps_cmd_t                   cmd,
    output logic [$clog2(PALETTE_DEPTH)-1:0]    rd_addr,
    output logic                                busy,
    output logic                                done
);

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);
    localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [AW-1:0]               addr_reg;
    logic [AW-1:0]               addr_next;
    logic                        done_reg;
    logic                        done_next;
    logic [nps_pkg::SIZE_W-1:0]  size_reg;

    logic          accept;
    logic [CW-1:0] limit;
    logic [CW-1:0] last;

    assign accept = start && (state_reg == ST_IDLE);

    // The read limit taken from the size register saturates at the memory depth.
    assign limit = (32'(size_reg) > PALETTE_DEPTH) ? CW'(PALETTE_DEPTH) : CW'(size_reg);
    assign last  = limit - CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        done_next       = 1'b0;
        cmd.wr_en       = 1'b0;
        cmd.clear_best  = 1'b0;
        cmd.rd_en       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == nps_pkg::ACT_WRITE)
                    begin
                        // Writes beyond the memory are dropped.
                        cmd.wr_en = (32'(entry_index) < PALETTE_DEPTH);
                    end
                    else
                    begin
                        cmd.clear_best = 1'b1;
                        addr_next      = '0;
                        if (limit == '0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (CW'(addr_reg) == last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            done_reg  <= 1'b0;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    assign rd_addr = addr_reg;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;

endmodule

// ----- rtl/nearest_palette_color_search_top.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// Finds the palette entry nearest to an RGB888 colour by squared distance.
// ----------------------------------------------------------------------------
// A write word is stored at its accepting edge and gives no result; busy stays low.
// A convert word raises done after N reads and a pipeline drain, N being palette_size
// saturated at PALETTE_DEPTH: the reads take one entry per cycle from the single read
// port, then the pipeline drains, then comes the done cycle, at whose ending edge
// the next word can be accepted. With an empty palette done is high in the cycle after
// acceptance. Reset clears the controller and palette_size; palette contents are kept.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top #(
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        action,
    input  logic [nps_pkg::IDX_W-1:0]   entry_index,
    input  logic [nps_pkg::COLOR_W-1:0] entry_color,
    input  logic [nps_pkg::COLOR_W-1:0] raw_color,
    input  logic                        cfg_wr_en,
    input  logic [nps_pkg::SIZE_W-1:0]  cfg_wr_data,
    output logic                        done,
    output logic [nps_pkg::IDX_W-1:0]   match_index
);

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);

    // Command and status between the sequencer and the datapath.
    nps_pkg::nps_cmd_t    cmd;
    nps_pkg::nps_status_t status;
    logic [AW-1:0]        rd_addr;

    // The sequencer accepts a word when start is high and busy is low. A write
    // word is stored in the same cycle. A convert word clears the running
    // best and then steps the read address from zero to the last slot in use.
    nps_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .entry_index (entry_index),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .busy        (busy),
        .done        (done)
    );

    // The datapath reads one entry per cycle, squares the three channel
    // differences in the next stage and updates the running minimum in the
    // stage after that. The winning index is held until the next convert.
    nps_datapath #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .wr_index   (entry_index),
        .wr_color   (entry_color),
        .raw_color  (raw_color),
        .status     (status),
        .best_index (match_index)
    );

endmodule
